/* hdl/mrmenc_pkg.sv */
// ----------------------------------------------------------------------------
// mrmenc_pkg
// Shared types and constants for the x86-64 ModRM/SIB/REX encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mrmenc_pkg;

  typedef struct packed {
    logic [31:0]        opcode_value;
    logic [31:0]        prefix_value;
    logic [1:0]         size_code;
    logic               skip_rex_w;
    logic [4:0]         reg_code;
    logic [1:0]         rm_mode;
    logic [4:0]         base_code;
    logic [4:0]         index_code;
    logic [3:0]         scale;
    logic signed [63:0] displacement;
  } req_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last_byte;
    logic [2:0] error_code;
  } rsp_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_NO_BASE   = 3'd1,
    ERR_BAD_SCALE = 3'd2,
    ERR_RBP_INDEX = 3'd3,
    ERR_RSP_INDEX = 3'd4,
    ERR_RIP_INDEX = 3'd5,
    ERR_DISP_WIDE = 3'd6
  } err_t;

  localparam logic [1:0] MODE_NO_BASE = 2'd0;
  localparam logic [1:0] MODE_BASE    = 2'd1;
  localparam logic [1:0] MODE_RIP     = 2'd2;
  localparam logic [1:0] MODE_DIRECT  = 2'd3;

  localparam logic [1:0] SIZE_WORD  = 2'd1;
  localparam logic [1:0] SIZE_QWORD = 2'd3;

  localparam logic [7:0] BYTE_OPSIZE = 8'h66;
  localparam logic [7:0] SIB_NO_IDX  = 8'h24;
  localparam logic [1:0] MOD_IND     = 2'b00;
  localparam logic [1:0] MOD_DISP8   = 2'b01;
  localparam logic [1:0] MOD_DISP32  = 2'b10;
  localparam logic [1:0] MOD_DIRECT  = 2'b11;
  localparam logic [2:0] RM_SIB      = 3'd4;
  localparam logic [2:0] RM_RIP      = 3'd5;
  localparam logic [3:0] REG_RSP     = 4'd4;
  localparam logic [3:0] REG_RBP     = 4'd5;

  // Fixed byte slots in an encoding descriptor, emitted lowest first.
  localparam int NUM_SLOTS   = 16;
  localparam int SLOT_PREFIX = 0;
  localparam int SLOT_OPSIZE = 4;
  localparam int SLOT_REX    = 5;
  localparam int SLOT_OPCODE = 6;
  localparam int SLOT_MODRM  = 10;
  localparam int SLOT_SIB    = 11;
  localparam int SLOT_DISP   = 12;

  typedef struct packed {
    logic [NUM_SLOTS-1:0][7:0] bytes;
    logic [NUM_SLOTS-1:0]      mask;
    err_t                      err;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [3:0] num;
    logic       frc;
  } reg_dec_t;

  function automatic reg_dec_t decode_reg(input logic [4:0] code);
    reg_dec_t d;
    d.num = code[3:0];
    d.frc = 1'b0;
    if (code[4:2] == 3'b100) begin
      d.num = {2'b01, code[1:0]};
      d.frc = 1'b1;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

/* hdl/mrmenc_front.sv */
// ----------------------------------------------------------------------------
// mrmenc_front
// Checks a request and lays out its encoded bytes as a slot descriptor.
// ----------------------------------------------------------------------------
`default_nettype none

module mrmenc_front (
  input  wire  mrmenc_pkg::req_t  req,
  output mrmenc_pkg::desc_t       desc
);

  mrmenc_pkg::reg_dec_t rd;
  mrmenc_pkg::reg_dec_t bd;
  logic        direct;
  logic        rip;
  logic        has_index;
  logic [3:0]  mbase;
  logic [3:0]  idx;
  logic [3:0]  rm_reg;
  logic        is_zero;
  logic        fits8;
  logic        fits32;
  logic        scale_ok;
  logic [1:0]  ss;
  logic [1:0]  mod_f;
  logic [2:0]  rm_f;
  logic        use_sib;
  logic [7:0]  sib;
  logic        disp1;
  logic        disp4;
  logic        rex_w;
  logic        rex_x;
  logic        rex_b;
  logic        rex_on;
  mrmenc_pkg::err_t err;
  logic [31:0] pv;
  logic [31:0] ov;
  logic [63:0] dv;

  always_comb begin
    rd        = mrmenc_pkg::decode_reg(req.reg_code);
    bd        = mrmenc_pkg::decode_reg(req.base_code);
    direct    = (req.rm_mode == mrmenc_pkg::MODE_DIRECT);
    rip       = (req.rm_mode == mrmenc_pkg::MODE_RIP);
    has_index = !req.index_code[4];
    mbase     = req.base_code[3:0];
    idx       = req.index_code[3:0];
    rm_reg    = direct ? bd.num : mbase;
    dv        = req.displacement;
    is_zero   = (dv == 64'd0);
    fits8     = (&dv[63:7]) || !(|dv[63:7]);
    fits32    = (&dv[63:31]) || !(|dv[63:31]);

    scale_ok = 1'b1;
    case (req.scale)
      4'd1:    ss = 2'd0;
      4'd2:    ss = 2'd1;
      4'd4:    ss = 2'd2;
      4'd8:    ss = 2'd3;
      default: begin
        ss       = 2'd0;
        scale_ok = 1'b0;
      end
    endcase

    err = mrmenc_pkg::ERR_NONE;
    if (!direct) begin
      if (req.rm_mode == mrmenc_pkg::MODE_NO_BASE) begin
        err = mrmenc_pkg::ERR_NO_BASE;
      end else if (has_index && !scale_ok) begin
        err = mrmenc_pkg::ERR_BAD_SCALE;
      end else if (has_index && !rip && mbase == mrmenc_pkg::REG_RBP) begin
        err = mrmenc_pkg::ERR_RBP_INDEX;
      end else if (has_index && idx == mrmenc_pkg::REG_RSP) begin
        err = mrmenc_pkg::ERR_RSP_INDEX;
      end else if (has_index && rip) begin
        err = mrmenc_pkg::ERR_RIP_INDEX;
      end else if (!fits32) begin
        err = mrmenc_pkg::ERR_DISP_WIDE;
      end
    end

    use_sib = 1'b0;
    sib     = mrmenc_pkg::SIB_NO_IDX;
    disp1   = 1'b0;
    disp4   = 1'b0;
    mod_f   = mrmenc_pkg::MOD_IND;
    rm_f    = rm_reg[2:0];
    if (direct) begin
      mod_f = mrmenc_pkg::MOD_DIRECT;
    end else if (rip) begin
      rm_f  = mrmenc_pkg::RM_RIP;
      disp4 = 1'b1;
    end else begin
      if (has_index) begin
        use_sib = 1'b1;
        rm_f    = mrmenc_pkg::RM_SIB;
        sib     = {ss, idx[2:0], mbase[2:0]};
      end else if (mbase[2:0] == mrmenc_pkg::REG_RSP[2:0]) begin
        use_sib = 1'b1;
        rm_f    = mrmenc_pkg::RM_SIB;
      end
      if (is_zero) begin
        if (mbase[2:0] == mrmenc_pkg::REG_RBP[2:0]) begin
          mod_f = mrmenc_pkg::MOD_DISP8;
          disp1 = 1'b1;
        end
      end else if (fits8) begin
        mod_f = mrmenc_pkg::MOD_DISP8;
        disp1 = 1'b1;
      end else begin
        mod_f = mrmenc_pkg::MOD_DISP32;
        disp4 = 1'b1;
      end
    end

    rex_w  = (req.size_code == mrmenc_pkg::SIZE_QWORD) && !req.skip_rex_w;
    rex_x  = !direct && !rip && has_index && idx[3];
    rex_b  = !rip && rm_reg[3];
    rex_on = rex_w || rd.num[3] || rex_x || rex_b || rd.frc || (direct && bd.frc);

    pv = req.prefix_value;
    ov = req.opcode_value;

    desc.bytes = {mrmenc_pkg::NUM_SLOTS{8'h00}};
    desc.bytes[mrmenc_pkg::SLOT_PREFIX+0] = pv[31:24];
    desc.bytes[mrmenc_pkg::SLOT_PREFIX+1] = pv[23:16];
    desc.bytes[mrmenc_pkg::SLOT_PREFIX+2] = pv[15:8];
    desc.bytes[mrmenc_pkg::SLOT_PREFIX+3] = pv[7:0];
    desc.bytes[mrmenc_pkg::SLOT_OPSIZE]   = mrmenc_pkg::BYTE_OPSIZE;
    desc.bytes[mrmenc_pkg::SLOT_REX]      = {4'h4, rex_w, rd.num[3], rex_x, rex_b};
    desc.bytes[mrmenc_pkg::SLOT_OPCODE+0] = ov[31:24];
    desc.bytes[mrmenc_pkg::SLOT_OPCODE+1] = ov[23:16];
    desc.bytes[mrmenc_pkg::SLOT_OPCODE+2] = ov[15:8];
    desc.bytes[mrmenc_pkg::SLOT_OPCODE+3] = ov[7:0];
    desc.bytes[mrmenc_pkg::SLOT_MODRM]    = {mod_f, rd.num[2:0], rm_f};
    desc.bytes[mrmenc_pkg::SLOT_SIB]      = sib;
    desc.bytes[mrmenc_pkg::SLOT_DISP+0]   = dv[7:0];
    desc.bytes[mrmenc_pkg::SLOT_DISP+1]   = dv[15:8];
    desc.bytes[mrmenc_pkg::SLOT_DISP+2]   = dv[23:16];
    desc.bytes[mrmenc_pkg::SLOT_DISP+3]   = dv[31:24];

    desc.mask = '0;
    desc.mask[mrmenc_pkg::SLOT_PREFIX+0] = |pv[31:24];
    desc.mask[mrmenc_pkg::SLOT_PREFIX+1] = |pv[31:16];
    desc.mask[mrmenc_pkg::SLOT_PREFIX+2] = |pv[31:8];
    desc.mask[mrmenc_pkg::SLOT_PREFIX+3] = |pv;
    desc.mask[mrmenc_pkg::SLOT_OPSIZE]   = (req.size_code == mrmenc_pkg::SIZE_WORD);
    desc.mask[mrmenc_pkg::SLOT_REX]      = rex_on;
    desc.mask[mrmenc_pkg::SLOT_OPCODE+0] = |ov[31:24];
    desc.mask[mrmenc_pkg::SLOT_OPCODE+1] = |ov[31:16];
    desc.mask[mrmenc_pkg::SLOT_OPCODE+2] = |ov[31:8];
    desc.mask[mrmenc_pkg::SLOT_OPCODE+3] = 1'b1;
    desc.mask[mrmenc_pkg::SLOT_MODRM]    = 1'b1;
    desc.mask[mrmenc_pkg::SLOT_SIB]      = use_sib;
    desc.mask[mrmenc_pkg::SLOT_DISP+0]   = disp1 || disp4;
    desc.mask[mrmenc_pkg::SLOT_DISP+1]   = disp4;
    desc.mask[mrmenc_pkg::SLOT_DISP+2]   = disp4;
    desc.mask[mrmenc_pkg::SLOT_DISP+3]   = disp4;

    if (err != mrmenc_pkg::ERR_NONE) begin
      desc.mask = '0;
    end
    desc.err = err;
  end

endmodule

`default_nettype wire

/* hdl/mrmenc_queue.sv */
// ----------------------------------------------------------------------------
// mrmenc_queue
// Two-entry descriptor queue between the classifier and the serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module mrmenc_queue (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     push,
  input  wire  mrmenc_pkg::desc_t push_data,
  input  wire                     pop,
  output mrmenc_pkg::desc_t       head,
  output mrmenc_pkg::q_stat_t     stat
);

  mrmenc_pkg::desc_t ent_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       do_push;
  logic       do_pop;

  always_comb begin
    stat.full  = (cnt_r == 2'd2);
    stat.empty = (cnt_r == 2'd0);
    do_push    = push && !stat.full;
    do_pop     = pop && !stat.empty;
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    head       = ent_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

/* hdl/mrmenc_back.sv */
// ----------------------------------------------------------------------------
// mrmenc_back
// Serializes the head descriptor one byte per cycle, while the output is not stalled, into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mrmenc_back (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire  mrmenc_pkg::desc_t head,
  input  wire  mrmenc_pkg::q_stat_t qstat,
  output logic                    pop,
  output logic                    out_valid,
  input  wire                     out_ready,
  output mrmenc_pkg::rsp_t        out_data
);

  logic                 started_r;
  logic                 started_nxt;
  logic [15:0]          rem_r;
  logic [15:0]          rem_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  mrmenc_pkg::rsp_t     out_data_r;
  mrmenc_pkg::rsp_t     out_data_nxt;
  logic                 adv;
  logic                 emit;
  logic [15:0]          eff_mask;
  logic [15:0]          lowbit;
  logic [15:0]          rest;
  logic [7:0]           sel_byte;
  logic                 is_err;
  logic                 done;

  always_comb begin
    adv      = !out_valid_r || out_ready;
    emit     = adv && !qstat.empty;
    eff_mask = started_r ? rem_r : head.mask;
    lowbit   = eff_mask & (~eff_mask + 16'd1);
    rest     = eff_mask & ~lowbit;
    sel_byte = 8'h00;
    for (int k = 0; k < mrmenc_pkg::NUM_SLOTS; k++) begin
      sel_byte = sel_byte | (head.bytes[k] & {8{lowbit[k]}});
    end
    is_err = (head.err != mrmenc_pkg::ERR_NONE);
    done   = is_err || (rest == 16'd0);
    pop    = emit && done;

    started_nxt   = started_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (adv) begin
      out_valid_nxt = emit;
      if (emit) begin
        started_nxt             = !done;
        rem_nxt                 = rest;
        out_data_nxt.code_byte  = is_err ? 8'h00 : sel_byte;
        out_data_nxt.last_byte  = done;
        out_data_nxt.error_code = head.err;
      end
    end

    out_valid = out_valid_r;
    out_data  = out_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

/* hdl/x86_64_modrm_encoder.sv */
// ----------------------------------------------------------------------------
// x86_64_modrm_encoder
// Encodes one x86-64 instruction request into its prefix, REX, opcode, ModRM,
// SIB and displacement bytes.
// ----------------------------------------------------------------------------
// Each accepted request yields its encoded bytes on the output channel, one
// byte per item, with last_byte set on the final one; an invalid request
// yields a single item carrying error_code and a zero byte. The output emits
// one item per cycle while out_ready does not stall it, and a request has 1 to
// 16 items. Requests are checked and laid out combinationally and held in a
// two-entry queue, so a new request is taken every cycle while that queue has
// room. The first byte of a request passes through its queue entry and then
// the output register before it is presented on the output when the queue and
// output are otherwise idle.
`default_nettype none

module x86_64_modrm_encoder (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire  mrmenc_pkg::req_t in_data,
  output logic                   out_valid,
  input  wire                    out_ready,
  output mrmenc_pkg::rsp_t       out_data
);

  mrmenc_pkg::desc_t   fr_desc;
  mrmenc_pkg::desc_t   q_head;
  mrmenc_pkg::q_stat_t q_stat;
  logic                q_pop;

  mrmenc_front u_front (
    .req  (in_data),
    .desc (fr_desc)
  );

  assign in_ready = !q_stat.full;

  mrmenc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_data (fr_desc),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  mrmenc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .qstat     (q_stat),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_accept_queued : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !q_stat.empty)
    else $error("accepted request did not reach the queue");

  a_error_shape : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error_code != mrmenc_pkg::ERR_NONE |->
      out_data.last_byte && out_data.code_byte == 8'h00)
    else $error("error item is not a single zero byte");

  a_pop_emits : assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_valid && out_data.last_byte)
    else $error("request retired without a final item");

  a_reset_quiet : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

`default_nettype wire
